// ----- design/scc_pkg.sv -----
// Shared constants and types for the condensed max path sum block.
// Used by scc_graph_store, scc_engine and scc_condensed_max_path_sum.
`default_nettype none

package scc_pkg;

   localparam int DEF_MAX_NODES = 1024;
   localparam int DEF_MAX_EDGES = 4096;

   localparam int NODE_NUM_W = 11;   // node numbers 1..1024 on the ports
   localparam int VALUE_W    = 16;
   localparam int RESULT_W   = 26;
   localparam int DIST_W     = 32;   // internal sums wrap at 32 bits

   // item kinds on req_tuser
   localparam logic [1:0] OP_EDGE = 2'd0;
   localparam logic [1:0] OP_NODE = 2'd1;
   localparam logic [1:0] OP_RUN  = 2'd2;

   // register indexes
   localparam logic CSR_NODE_COUNT = 1'b0;
   localparam logic CSR_START_NODE = 1'b1;

   typedef struct packed {
      logic                  edge_we;
      logic                  node_we;
      logic [NODE_NUM_W-1:0] src_node;
      logic [NODE_NUM_W-1:0] dst_node;
      logic [VALUE_W-1:0]    node_value;
      logic                  is_target;
   } load_cmd_type;

endpackage

`default_nettype wire

// ----- design/scc_graph_store.sv -----
// Graph store: edge head/link memories, per-node list heads and node values.
// Depends on scc_pkg; read ports serve the load path and scc_engine.
`default_nettype none

module scc_graph_store #(
   parameter int MAX_NODES = scc_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = scc_pkg::DEF_MAX_EDGES
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire scc_pkg::load_cmd_type                 load_i,
   input  wire logic [$clog2(MAX_NODES)-1:0]          node_ra_i,
   input  wire logic [$clog2(MAX_EDGES)-1:0]          edge_ra_i,
   output logic      [$clog2(MAX_EDGES+1)-1:0]        lh_o,
   output logic      [scc_pkg::VALUE_W-1:0]           value_o,
   output logic                                       tgt_o,
   output logic      [scc_pkg::NODE_NUM_W-1:0]        ehead_o,
   output logic      [$clog2(MAX_EDGES+1)-1:0]        enext_o,
   output logic                                       ready_o
);
   import scc_pkg::*;

   localparam int NW  = $clog2(MAX_NODES);
   localparam int CW  = $clog2(MAX_NODES+1);
   localparam int EIW = $clog2(MAX_EDGES);
   localparam int LW  = $clog2(MAX_EDGES+1);

   logic [LW-1:0]            lh_mem    [MAX_NODES];
   logic [VALUE_W:0]         node_mem  [MAX_NODES];
   logic [NODE_NUM_W-1:0]    ehead_mem [MAX_EDGES];
   logic [LW-1:0]            enext_mem [MAX_EDGES];

   logic [LW-1:0]            lh_rd_ff;
   logic [VALUE_W:0]         node_rd_ff;
   logic [NODE_NUM_W-1:0]    ehead_rd_ff;
   logic [LW-1:0]            enext_rd_ff;

   logic                     clr_busy_ff, clr_busy_in;
   logic [CW-1:0]            clr_idx_ff, clr_idx_in;
   logic [LW-1:0]            edge_total_ff, edge_total_in;
   logic                     pend_ff, pend_in;
   logic [EIW-1:0]           pend_idx_ff, pend_idx_in;

   logic                     edge_ok, node_ok;
   logic [NW-1:0]            src_idx;
   logic                     lh_we;
   logic [NW-1:0]            lh_wa, lh_ra;
   logic [LW-1:0]            lh_wd;

   assign src_idx = NW'(load_i.src_node - 11'd1);
   assign edge_ok = load_i.edge_we && (32'(edge_total_ff) < 32'(MAX_EDGES))
                 && (load_i.src_node != '0) && (32'(load_i.src_node) <= 32'(MAX_NODES))
                 && (load_i.dst_node != '0) && (32'(load_i.dst_node) <= 32'(MAX_NODES));
   assign node_ok = load_i.node_we && (load_i.src_node != '0)
                 && (32'(load_i.src_node) <= 32'(MAX_NODES));

   always_comb begin
      lh_we = 1'b0;
      lh_wa = src_idx;
      lh_wd = edge_total_ff + 1'b1;
      if (clr_busy_ff) begin
         lh_we = 1'b1;
         lh_wa = NW'(clr_idx_ff);
         lh_wd = '0;
      end else if (edge_ok) begin
         lh_we = 1'b1;
      end
      // old list head is read in the same cycle as the new head is written
      lh_ra = load_i.edge_we ? src_idx : node_ra_i;
   end

   always_comb begin
      clr_busy_in   = clr_busy_ff;
      clr_idx_in    = clr_idx_ff;
      edge_total_in = edge_total_ff;
      pend_in       = edge_ok;
      pend_idx_in   = EIW'(edge_total_ff);
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (32'(clr_idx_ff) == 32'(MAX_NODES - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
      if (edge_ok) begin
         edge_total_in = edge_total_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff   <= 1'b1;
         clr_idx_ff    <= '0;
         edge_total_ff <= '0;
         pend_ff       <= 1'b0;
      end else begin
         clr_busy_ff   <= clr_busy_in;
         clr_idx_ff    <= clr_idx_in;
         edge_total_ff <= edge_total_in;
         pend_ff       <= pend_in;
      end
      pend_idx_ff <= pend_idx_in;
   end

   always_ff @(posedge clock) begin
      if (lh_we) lh_mem[lh_wa] <= lh_wd;
      lh_rd_ff <= lh_mem[lh_ra];
   end

   always_ff @(posedge clock) begin
      if (node_ok) node_mem[src_idx] <= {load_i.is_target, load_i.node_value};
      node_rd_ff <= node_mem[node_ra_i];
   end

   always_ff @(posedge clock) begin
      if (edge_ok) ehead_mem[EIW'(edge_total_ff)] <= load_i.dst_node;
      ehead_rd_ff <= ehead_mem[edge_ra_i];
   end

   // link of the edge loaded last cycle takes the list head read then
   always_ff @(posedge clock) begin
      if (pend_ff) enext_mem[pend_idx_ff] <= lh_rd_ff;
      enext_rd_ff <= enext_mem[edge_ra_i];
   end

   assign lh_o    = lh_rd_ff;
   assign value_o = node_rd_ff[VALUE_W-1:0];
   assign tgt_o   = node_rd_ff[VALUE_W];
   assign ehead_o = ehead_rd_ff;
   assign enext_o = enext_rd_ff;
   assign ready_o = !clr_busy_ff;

endmodule

`default_nettype wire

// ----- design/scc_engine.sv -----
// Run sequencer: iterative Tarjan SCC walk, then relaxation over components.
// Depends on scc_pkg; reads the graph through scc_graph_store's ports.
`default_nettype none

module scc_engine #(
   parameter int MAX_NODES = scc_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = scc_pkg::DEF_MAX_EDGES
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start_i,
   input  wire logic [scc_pkg::NODE_NUM_W-1:0]        node_count_i,
   input  wire logic [scc_pkg::NODE_NUM_W-1:0]        start_node_i,
   output logic      [$clog2(MAX_NODES)-1:0]          node_ra_o,
   output logic      [$clog2(MAX_EDGES)-1:0]          edge_ra_o,
   input  wire logic [$clog2(MAX_EDGES+1)-1:0]        lh_i,
   input  wire logic [scc_pkg::VALUE_W-1:0]           value_i,
   input  wire logic                                  tgt_i,
   input  wire logic [scc_pkg::NODE_NUM_W-1:0]        ehead_i,
   input  wire logic [$clog2(MAX_EDGES+1)-1:0]        enext_i,
   output logic                                       busy_o,
   output logic                                       done_o,
   output logic      [scc_pkg::RESULT_W-1:0]          result_o
);
   import scc_pkg::*;

   localparam int NW  = $clog2(MAX_NODES);
   localparam int CW  = $clog2(MAX_NODES+1);
   localparam int EIW = $clog2(MAX_EDGES);
   localparam int LW  = $clog2(MAX_EDGES+1);

   typedef struct packed {
      logic              tgt;
      logic [NW-1:0]     first;
      logic [CW-1:0]     len;
      logic [DIST_W-1:0] sum;
   } comp_type;

   typedef struct packed {
      logic [NW-1:0] node;
      logic [LW-1:0] cur;
   } walk_type;

   typedef enum logic [5:0] {
      S_IDLE, S_CLEAR, S_ROOT_RD, S_ROOT_CHK, S_WALK, S_EDGE, S_VCHK, S_LMIN,
      S_POP, S_POP2, S_POP3, S_POP4, S_COMP, S_SPOP_RD, S_SPOP_W, S_SPOP_V,
      S_REL_START, S_REL_S1, S_REL_S2, S_Q_POP, S_Q_P1, S_Q_P2, S_MEM_NEXT,
      S_MEM_W, S_MEM_LH, S_EW_CHK, S_REL_E, S_REL_C, S_REL_D, S_ANS_RD,
      S_ANS_CHK, S_DONE
   } state_type;

   // memories
   logic [CW-1:0]     visit_mem  [MAX_NODES];
   logic [CW-1:0]     low_mem    [MAX_NODES];
   logic              onstk_mem  [MAX_NODES];
   logic [NW-1:0]     compof_mem [MAX_NODES];
   logic [NW-1:0]     nstack_mem [MAX_NODES];
   walk_type          walk_mem   [MAX_NODES];
   logic [NW-1:0]     member_mem [MAX_NODES];
   comp_type          comp_mem   [MAX_NODES];
   logic [DIST_W-1:0] dist_mem   [MAX_NODES];
   logic [1:0]        rq_mem     [MAX_NODES];   // {reached, queued}
   logic [NW-1:0]     queue_mem  [MAX_NODES];

   logic [CW-1:0]     visit_rd_ff, low_rd_ff;
   logic              onstk_rd_ff;
   logic [NW-1:0]     compof_rd_ff, nstack_rd_ff, member_rd_ff, queue_rd_ff;
   walk_type          walk_rd_ff;
   comp_type          comp_rd_ff;
   logic [DIST_W-1:0] dist_rd_ff;
   logic [1:0]        rq_rd_ff;

   logic visit_we, low_we, onstk_we, compof_we, nstack_we, walk_we;
   logic member_we, comp_we, dist_we, rq_we, queue_we;
   logic [NW-1:0] visit_wa, low_wa, onstk_wa, compof_wa, nstack_wa, walk_wa;
   logic [NW-1:0] member_wa, comp_wa, dist_wa, rq_wa, queue_wa;
   logic [NW-1:0] visit_ra, low_ra, onstk_ra, compof_ra, nstack_ra, walk_ra;
   logic [NW-1:0] member_ra, comp_ra, dist_ra, rq_ra, queue_ra;
   logic [CW-1:0]     visit_wd, low_wd;
   logic              onstk_wd;
   logic [NW-1:0]     compof_wd, nstack_wd, member_wd, queue_wd;
   walk_type          walk_wd;
   comp_type          comp_wd;
   logic [DIST_W-1:0] dist_wd;
   logic [1:0]        rq_wd;

   // sequencer registers
   state_type         state_ff, state_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     n_ff, n_in;
   logic [NW-1:0]     start_ff, start_in;
   logic [CW-1:0]     counter_ff, counter_in;
   logic [CW-1:0]     stop_ff, stop_in;
   logic [CW-1:0]     wtop_ff, wtop_in;
   logic [CW-1:0]     members_ff, members_in;
   logic [CW-1:0]     comps_ff, comps_in;
   logic [NW-1:0]     u_ff, u_in;
   logic [LW-1:0]     cur_ff, cur_in;
   logic [NW-1:0]     v_ff, v_in;
   logic [CW-1:0]     visv_ff, visv_in;
   logic [CW-1:0]     lowu_ff, lowu_in;
   logic [CW-1:0]     visu_ff, visu_in;
   logic [NW-1:0]     cu_ff, cu_in;
   logic [NW-1:0]     cfirst_ff, cfirst_in;
   logic [CW-1:0]     clen_ff, clen_in;
   logic [DIST_W-1:0] csum_ff, csum_in;
   logic              ctgt_ff, ctgt_in;
   logic [NW-1:0]     w_ff, w_in;
   logic [NW-1:0]     c_ff, c_in;
   logic [DIST_W-1:0] distc_ff, distc_in;
   logic [CW-1:0]     k_ff, k_in;
   logic [NW-1:0]     kfirst_ff, kfirst_in;
   logic [CW-1:0]     klen_ff, klen_in;
   logic [NW-1:0]     qhead_ff, qhead_in;
   logic [CW-1:0]     qcount_ff, qcount_in;
   logic [DIST_W-1:0] answer_ff, answer_in;
   logic              done_ff, done_in;
   logic [RESULT_W-1:0] result_ff, result_in;

   logic [CW-1:0]     n_eff, cnt_next;
   logic              start_ok, head_ok;
   logic [NW-1:0]     head_idx, qhead_next, qtail;
   logic [31:0]       tail_sum;
   logic [DIST_W-1:0] csum_new, d_new;
   logic              ctgt_new;

   assign n_eff = (32'(node_count_i) > 32'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(node_count_i);
   assign start_ok = (start_node_i != '0) && (32'(start_node_i) <= 32'(n_eff));
   assign cnt_next = counter_ff + 1'b1;
   assign head_ok  = (ehead_i != '0) && (32'(ehead_i) <= 32'(n_ff));
   assign head_idx = NW'(ehead_i - 11'd1);
   assign qhead_next = (32'(qhead_ff) + 32'd1 == 32'(MAX_NODES)) ? '0 : qhead_ff + 1'b1;
   assign tail_sum = 32'(qhead_ff) + 32'(qcount_ff);
   assign qtail = (tail_sum >= 32'(MAX_NODES)) ? NW'(tail_sum - 32'(MAX_NODES)) : NW'(tail_sum);
   assign csum_new = csum_ff + DIST_W'(value_i);
   assign ctgt_new = ctgt_ff | tgt_i;
   assign d_new    = distc_ff + comp_rd_ff.sum;

   always_comb begin
      state_in = state_ff;   idx_in = idx_ff;       n_in = n_ff;
      start_in = start_ff;   counter_in = counter_ff; stop_in = stop_ff;
      wtop_in = wtop_ff;     members_in = members_ff; comps_in = comps_ff;
      u_in = u_ff;           cur_in = cur_ff;       v_in = v_ff;
      visv_in = visv_ff;     lowu_in = lowu_ff;     visu_in = visu_ff;
      cu_in = cu_ff;         cfirst_in = cfirst_ff; clen_in = clen_ff;
      csum_in = csum_ff;     ctgt_in = ctgt_ff;     w_in = w_ff;
      c_in = c_ff;           distc_in = distc_ff;   k_in = k_ff;
      kfirst_in = kfirst_ff; klen_in = klen_ff;     qhead_in = qhead_ff;
      qcount_in = qcount_ff; answer_in = answer_ff; result_in = result_ff;
      done_in = 1'b0;

      visit_we = 1'b0; low_we = 1'b0; onstk_we = 1'b0; compof_we = 1'b0;
      nstack_we = 1'b0; walk_we = 1'b0; member_we = 1'b0; comp_we = 1'b0;
      dist_we = 1'b0; rq_we = 1'b0; queue_we = 1'b0;
      visit_wa = '0; low_wa = '0; onstk_wa = '0; compof_wa = '0; nstack_wa = '0;
      walk_wa = '0; member_wa = '0; comp_wa = '0; dist_wa = '0; rq_wa = '0;
      queue_wa = '0;
      visit_ra = '0; low_ra = '0; onstk_ra = '0; compof_ra = '0; nstack_ra = '0;
      walk_ra = '0; member_ra = '0; comp_ra = '0; dist_ra = '0; rq_ra = '0;
      queue_ra = '0;
      visit_wd = '0; low_wd = '0; onstk_wd = 1'b0; compof_wd = '0; nstack_wd = '0;
      walk_wd = '0; member_wd = '0; comp_wd = '0; dist_wd = '0; rq_wd = '0;
      queue_wd = '0;
      node_ra_o = '0;
      edge_ra_o = '0;

      case (state_ff)
         S_IDLE: begin
            if (start_i) begin
               n_in = n_eff;
               start_in = NW'(start_node_i - 11'd1);
               idx_in = '0; counter_in = '0; stop_in = '0; wtop_in = '0;
               members_in = '0; comps_in = '0; qhead_in = '0; qcount_in = '0;
               answer_in = '0;
               if (start_ok) begin
                  state_in = S_CLEAR;
               end else begin
                  result_in = '0;
                  state_in  = S_DONE;
               end
            end
         end
         S_CLEAR: begin
            // per-run marks for nodes and components share the sweep
            visit_we = 1'b1; visit_wa = NW'(idx_ff);
            onstk_we = 1'b1; onstk_wa = NW'(idx_ff);
            rq_we    = 1'b1; rq_wa    = NW'(idx_ff);
            idx_in = idx_ff + 1'b1;
            if (idx_ff + 1'b1 == n_ff) begin
               idx_in   = '0;
               state_in = S_ROOT_RD;
            end
         end
         S_ROOT_RD: begin
            if (idx_ff == n_ff) begin
               state_in = S_REL_START;
            end else begin
               visit_ra  = NW'(idx_ff);
               node_ra_o = NW'(idx_ff);
               state_in  = S_ROOT_CHK;
            end
         end
         S_ROOT_CHK: begin
            if (visit_rd_ff != '0) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_ROOT_RD;
            end else begin
               visit_we = 1'b1; visit_wa = NW'(idx_ff); visit_wd = cnt_next;
               low_we   = 1'b1; low_wa   = NW'(idx_ff); low_wd   = cnt_next;
               onstk_we = 1'b1; onstk_wa = NW'(idx_ff); onstk_wd = 1'b1;
               nstack_we = 1'b1; nstack_wa = NW'(stop_ff); nstack_wd = NW'(idx_ff);
               counter_in = cnt_next;
               stop_in = stop_ff + 1'b1;
               wtop_in = CW'(1);
               u_in    = NW'(idx_ff);
               cur_in  = lh_i;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (cur_ff != '0) begin
               edge_ra_o = EIW'(cur_ff - 1'b1);
               state_in  = S_EDGE;
            end else begin
               state_in = S_POP;
            end
         end
         S_EDGE: begin
            cur_in = enext_i;
            if (head_ok) begin
               v_in = head_idx;
               visit_ra = head_idx; onstk_ra = head_idx; node_ra_o = head_idx;
               state_in = S_VCHK;
            end else begin
               state_in = S_WALK;
            end
         end
         S_VCHK: begin
            if (visit_rd_ff == '0) begin
               // descend: park the current node with its advanced cursor
               walk_we = 1'b1; walk_wa = NW'(wtop_ff - 1'b1);
               walk_wd = '{node: u_ff, cur: cur_ff};
               visit_we = 1'b1; visit_wa = v_ff; visit_wd = cnt_next;
               low_we   = 1'b1; low_wa   = v_ff; low_wd   = cnt_next;
               onstk_we = 1'b1; onstk_wa = v_ff; onstk_wd = 1'b1;
               nstack_we = 1'b1; nstack_wa = NW'(stop_ff); nstack_wd = v_ff;
               counter_in = cnt_next;
               stop_in = stop_ff + 1'b1;
               wtop_in = wtop_ff + 1'b1;
               u_in    = v_ff;
               cur_in  = lh_i;
               state_in = S_WALK;
            end else if (onstk_rd_ff) begin
               visv_in  = visit_rd_ff;
               low_ra   = u_ff;
               state_in = S_LMIN;
            end else begin
               state_in = S_WALK;
            end
         end
         S_LMIN: begin
            low_we = 1'b1; low_wa = u_ff;
            low_wd = (visv_ff < low_rd_ff) ? visv_ff : low_rd_ff;
            state_in = S_WALK;
         end
         S_POP: begin
            low_ra = u_ff; visit_ra = u_ff;
            state_in = S_POP2;
         end
         S_POP2: begin
            lowu_in = low_rd_ff;
            visu_in = visit_rd_ff;
            cu_in   = u_ff;
            wtop_in = wtop_ff - 1'b1;
            if (wtop_ff > CW'(1)) begin
               walk_ra  = NW'(wtop_ff - CW'(2));
               state_in = S_POP3;
            end else begin
               state_in = S_COMP;
            end
         end
         S_POP3: begin
            u_in   = walk_rd_ff.node;
            cur_in = walk_rd_ff.cur;
            low_ra = walk_rd_ff.node;
            state_in = S_POP4;
         end
         S_POP4: begin
            low_we = 1'b1; low_wa = u_ff;
            low_wd = (lowu_ff < low_rd_ff) ? lowu_ff : low_rd_ff;
            state_in = S_COMP;
         end
         S_COMP: begin
            if (lowu_ff == visu_ff) begin
               csum_in = '0; ctgt_in = 1'b0; clen_in = '0;
               cfirst_in = NW'(members_ff);
               state_in = S_SPOP_RD;
            end else if (wtop_ff == '0) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_ROOT_RD;
            end else begin
               state_in = S_WALK;
            end
         end
         S_SPOP_RD: begin
            nstack_ra = NW'(stop_ff - 1'b1);
            stop_in   = stop_ff - 1'b1;
            state_in  = S_SPOP_W;
         end
         S_SPOP_W: begin
            w_in = nstack_rd_ff;
            onstk_we  = 1'b1; onstk_wa  = nstack_rd_ff; onstk_wd = 1'b0;
            compof_we = 1'b1; compof_wa = nstack_rd_ff; compof_wd = NW'(comps_ff);
            member_we = 1'b1; member_wa = NW'(members_ff); member_wd = nstack_rd_ff;
            members_in = members_ff + 1'b1;
            clen_in    = clen_ff + 1'b1;
            node_ra_o  = nstack_rd_ff;
            state_in   = S_SPOP_V;
         end
         S_SPOP_V: begin
            csum_in = csum_new;
            ctgt_in = ctgt_new;
            if (w_ff == cu_ff || stop_ff == '0) begin
               comp_we = 1'b1; comp_wa = NW'(comps_ff);
               comp_wd = '{tgt: ctgt_new, first: cfirst_ff, len: clen_ff, sum: csum_new};
               comps_in = comps_ff + 1'b1;
               if (wtop_ff == '0) begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_ROOT_RD;
               end else begin
                  state_in = S_WALK;
               end
            end else begin
               state_in = S_SPOP_RD;
            end
         end
         S_REL_START: begin
            compof_ra = start_ff;
            state_in  = S_REL_S1;
         end
         S_REL_S1: begin
            c_in    = compof_rd_ff;
            comp_ra = compof_rd_ff;
            state_in = S_REL_S2;
         end
         S_REL_S2: begin
            dist_we  = 1'b1; dist_wa  = c_ff; dist_wd = comp_rd_ff.sum;
            rq_we    = 1'b1; rq_wa    = c_ff; rq_wd   = 2'b11;
            queue_we = 1'b1; queue_wa = '0;   queue_wd = c_ff;
            qhead_in  = '0;
            qcount_in = CW'(1);
            state_in  = S_Q_POP;
         end
         S_Q_POP: begin
            if (qcount_ff == '0) begin
               idx_in   = '0;
               state_in = S_ANS_RD;
            end else begin
               queue_ra = qhead_ff;
               state_in = S_Q_P1;
            end
         end
         S_Q_P1: begin
            c_in      = queue_rd_ff;
            qhead_in  = qhead_next;
            qcount_in = qcount_ff - 1'b1;
            rq_we = 1'b1; rq_wa = queue_rd_ff; rq_wd = 2'b10;
            comp_ra = queue_rd_ff; dist_ra = queue_rd_ff;
            state_in = S_Q_P2;
         end
         S_Q_P2: begin
            kfirst_in = comp_rd_ff.first;
            klen_in   = comp_rd_ff.len;
            distc_in  = dist_rd_ff;
            k_in      = '0;
            state_in  = S_MEM_NEXT;
         end
         S_MEM_NEXT: begin
            if (k_ff == klen_ff) begin
               state_in = S_Q_POP;
            end else begin
               member_ra = NW'(32'(kfirst_ff) + 32'(k_ff));
               state_in  = S_MEM_W;
            end
         end
         S_MEM_W: begin
            node_ra_o = member_rd_ff;
            k_in      = k_ff + 1'b1;
            state_in  = S_MEM_LH;
         end
         S_MEM_LH: begin
            cur_in   = lh_i;
            state_in = S_EW_CHK;
         end
         S_EW_CHK: begin
            if (cur_ff == '0) begin
               state_in = S_MEM_NEXT;
            end else begin
               edge_ra_o = EIW'(cur_ff - 1'b1);
               state_in  = S_REL_E;
            end
         end
         S_REL_E: begin
            cur_in = enext_i;
            if (head_ok) begin
               compof_ra = head_idx;
               state_in  = S_REL_C;
            end else begin
               state_in = S_EW_CHK;
            end
         end
         S_REL_C: begin
            v_in = compof_rd_ff;
            if (compof_rd_ff == c_ff) begin
               state_in = S_EW_CHK;
            end else begin
               comp_ra = compof_rd_ff; dist_ra = compof_rd_ff; rq_ra = compof_rd_ff;
               state_in = S_REL_D;
            end
         end
         S_REL_D: begin
            if (!rq_rd_ff[1] || dist_rd_ff < d_new) begin
               dist_we = 1'b1; dist_wa = v_ff; dist_wd = d_new;
               rq_we   = 1'b1; rq_wa   = v_ff; rq_wd   = 2'b11;
               if (!rq_rd_ff[0]) begin
                  queue_we = 1'b1; queue_wa = qtail; queue_wd = v_ff;
                  qcount_in = qcount_ff + 1'b1;
               end
            end
            state_in = S_EW_CHK;
         end
         S_ANS_RD: begin
            if (idx_ff == comps_ff) begin
               result_in = answer_ff[RESULT_W-1:0];
               state_in  = S_DONE;
            end else begin
               comp_ra = NW'(idx_ff); dist_ra = NW'(idx_ff); rq_ra = NW'(idx_ff);
               state_in = S_ANS_CHK;
            end
         end
         S_ANS_CHK: begin
            if (comp_rd_ff.tgt && rq_rd_ff[1] && dist_rd_ff > answer_ff) begin
               answer_in = dist_rd_ff;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = S_ANS_RD;
         end
         S_DONE: begin
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         done_ff    <= 1'b0;
         counter_ff <= '0;
         stop_ff    <= '0;
         wtop_ff    <= '0;
         comps_ff   <= '0;
         qcount_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         done_ff    <= done_in;
         counter_ff <= counter_in;
         stop_ff    <= stop_in;
         wtop_ff    <= wtop_in;
         comps_ff   <= comps_in;
         qcount_ff  <= qcount_in;
      end
      idx_ff <= idx_in;       n_ff <= n_in;           start_ff <= start_in;
      members_ff <= members_in; u_ff <= u_in;         cur_ff <= cur_in;
      v_ff <= v_in;           visv_ff <= visv_in;     lowu_ff <= lowu_in;
      visu_ff <= visu_in;     cu_ff <= cu_in;         cfirst_ff <= cfirst_in;
      clen_ff <= clen_in;     csum_ff <= csum_in;     ctgt_ff <= ctgt_in;
      w_ff <= w_in;           c_ff <= c_in;           distc_ff <= distc_in;
      k_ff <= k_in;           kfirst_ff <= kfirst_in; klen_ff <= klen_in;
      qhead_ff <= qhead_in;   answer_ff <= answer_in; result_ff <= result_in;
   end

   always_ff @(posedge clock) begin
      if (visit_we) visit_mem[visit_wa] <= visit_wd;
      visit_rd_ff <= visit_mem[visit_ra];
   end
   always_ff @(posedge clock) begin
      if (low_we) low_mem[low_wa] <= low_wd;
      low_rd_ff <= low_mem[low_ra];
   end
   always_ff @(posedge clock) begin
      if (onstk_we) onstk_mem[onstk_wa] <= onstk_wd;
      onstk_rd_ff <= onstk_mem[onstk_ra];
   end
   always_ff @(posedge clock) begin
      if (compof_we) compof_mem[compof_wa] <= compof_wd;
      compof_rd_ff <= compof_mem[compof_ra];
   end
   always_ff @(posedge clock) begin
      if (nstack_we) nstack_mem[nstack_wa] <= nstack_wd;
      nstack_rd_ff <= nstack_mem[nstack_ra];
   end
   always_ff @(posedge clock) begin
      if (walk_we) walk_mem[walk_wa] <= walk_wd;
      walk_rd_ff <= walk_mem[walk_ra];
   end
   always_ff @(posedge clock) begin
      if (member_we) member_mem[member_wa] <= member_wd;
      member_rd_ff <= member_mem[member_ra];
   end
   always_ff @(posedge clock) begin
      if (comp_we) comp_mem[comp_wa] <= comp_wd;
      comp_rd_ff <= comp_mem[comp_ra];
   end
   always_ff @(posedge clock) begin
      if (dist_we) dist_mem[dist_wa] <= dist_wd;
      dist_rd_ff <= dist_mem[dist_ra];
   end
   always_ff @(posedge clock) begin
      if (rq_we) rq_mem[rq_wa] <= rq_wd;
      rq_rd_ff <= rq_mem[rq_ra];
   end
   always_ff @(posedge clock) begin
      if (queue_we) queue_mem[queue_wa] <= queue_wd;
      queue_rd_ff <= queue_mem[queue_ra];
   end

   assign busy_o   = (state_ff != S_IDLE) || done_ff;
   assign done_o   = done_ff;
   assign result_o = result_ff;

   // every node on the walk stack is also on the node stack
   a_walk_within_stack: assert property (@(posedge clock) disable iff (reset)
      wtop_ff <= stop_ff) else $error("walk stack deeper than node stack");
   // node stack holds only nodes numbered in this run
   a_stack_within_count: assert property (@(posedge clock) disable iff (reset)
      stop_ff <= counter_ff) else $error("node stack deeper than visited count");
   // a component is queued at most once
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qcount_ff <= comps_ff) else $error("work queue holds more than the components");

endmodule

`default_nettype wire

// ----- design/scc_condensed_max_path_sum.sv -----
// Top level: stream ports, config registers, result register.
// Depends on scc_pkg, scc_graph_store and scc_engine.
//
//  channel  dir  handshake             payload
//  req_     in   req_tvalid/tready     tuser: op; tdata: src, dst, value, target
//  rsp_     out  rsp_tvalid/tready     tdata: best_sum
//  csr_     in   csr_we                csr_addr, csr_wdata
//
// Load items are taken one a cycle while req_tready is high, and the graph store
// writes one edge or node a cycle. A run item clears the per-run marks of the N nodes,
// then walks the graph one memory access a step: a Tarjan SCC pass, then a relaxation
// pass over queued components, their members and edges, then a scan for the answer.
// After reset the list heads of all MAX_NODES nodes are cleared while req_tready is low.
// A new item is taken only while no result waits on rsp_.
`default_nettype none

module scc_condensed_max_path_sum #(
   parameter int MAX_NODES = scc_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = scc_pkg::DEF_MAX_EDGES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // src_node[10:0], dst_node[21:11],
                                         // node_value[37:22], is_target[38]
   input  wire logic [1:0]  req_tuser,   // op[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // best_sum[25:0]
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [10:0] csr_wdata
);
   import scc_pkg::*;

   localparam int NW  = $clog2(MAX_NODES);
   localparam int EIW = $clog2(MAX_EDGES);
   localparam int LW  = $clog2(MAX_EDGES+1);

   logic [NODE_NUM_W-1:0] node_count_ff, start_node_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RESULT_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                  req_acc, run_start, store_ready, eng_busy, eng_done;
   load_cmd_type          load_cmd;
   logic [NW-1:0]         node_ra;
   logic [EIW-1:0]        edge_ra;
   logic [LW-1:0]         lh, enext;
   logic [VALUE_W-1:0]    value;
   logic                  tgt;
   logic [NODE_NUM_W-1:0] ehead;
   logic [RESULT_W-1:0]   eng_result;

   assign req_tready = store_ready && !eng_busy && !rsp_valid_ff;
   assign req_acc    = req_tvalid && req_tready;
   assign run_start  = req_acc && (req_tuser == OP_RUN);

   assign load_cmd.edge_we    = req_acc && (req_tuser == OP_EDGE);
   assign load_cmd.node_we    = req_acc && (req_tuser == OP_NODE);
   assign load_cmd.src_node   = req_tdata[10:0];
   assign load_cmd.dst_node   = req_tdata[21:11];
   assign load_cmd.node_value = req_tdata[37:22];
   assign load_cmd.is_target  = req_tdata[38];

   scc_graph_store #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_store (
      .clock     (clock),
      .reset     (reset),
      .load_i    (load_cmd),
      .node_ra_i (node_ra),
      .edge_ra_i (edge_ra),
      .lh_o      (lh),
      .value_o   (value),
      .tgt_o     (tgt),
      .ehead_o   (ehead),
      .enext_o   (enext),
      .ready_o   (store_ready)
   );

   scc_engine #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_engine (
      .clock        (clock),
      .reset        (reset),
      .start_i      (run_start),
      .node_count_i (node_count_ff),
      .start_node_i (start_node_ff),
      .node_ra_o    (node_ra),
      .edge_ra_o    (edge_ra),
      .lh_i         (lh),
      .value_i      (value),
      .tgt_i        (tgt),
      .ehead_i      (ehead),
      .enext_i      (enext),
      .busy_o       (eng_busy),
      .done_o       (eng_done),
      .result_o     (eng_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (eng_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_NUM_W'(1);
         start_node_ff <= NODE_NUM_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we && csr_addr == CSR_NODE_COUNT) node_count_ff <= csr_wdata;
         if (csr_we && csr_addr == CSR_START_NODE) start_node_ff <= csr_wdata;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

   // nothing is taken in while a result waits
   a_hold_while_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("item accepted with result pending");
   // a finished run always lands in an empty result register
   a_done_into_empty: assert property (@(posedge clock) disable iff (reset)
      eng_done |-> !rsp_valid_ff) else $error("result overwritten");
   // a run start is always taken up by the engine
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      run_start |=> eng_busy) else $error("run start not taken");

endmodule

`default_nettype wire
